// ===== hdl/tgan_pkg.sv =====
// Shared types and constants for the tangent averaging block.
`timescale 1ns / 1ps

package tgan_pkg;

   localparam int IDX_BITS = 12;   // vertex index field width
   localparam int PRES_W   = 32;   // presence flags held per memory row
   localparam int PB       = 5;    // log2 of PRES_W

   typedef struct packed {
      logic busy;
      logic done;
   } norm_stat_type;

endpackage

// ===== hdl/tgan_norm.sv =====
// Iterative normaliser: scales a three-component sum to unit length in Q1.14.
`timescale 1ns / 1ps

module tgan_norm #(
   parameter int ACC_BITS  = 24,
   parameter int COMP_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ACC_BITS-1:0]           sum_x,
   input  logic [ACC_BITS-1:0]           sum_y,
   input  logic [ACC_BITS-1:0]           sum_z,
   output tgan_pkg::norm_stat_type       stat,
   output logic [COMP_BITS-1:0]          norm_x,
   output logic [COMP_BITS-1:0]          norm_y,
   output logic [COMP_BITS-1:0]          norm_z
);

   localparam int MW = (ACC_BITS > 30) ? ACC_BITS : 30;
   localparam int QB = COMP_BITS - 1;
   localparam int DW = COMP_BITS + 31;

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_SQRT  = 3'd3;
   localparam logic [2:0] N_DLD   = 3'd4;
   localparam logic [2:0] N_DIV   = 3'd5;

   logic [2:0]           state_ff;
   logic [MW-1:0]        a_ff, b_ff, c_ff;
   logic [2:0]           neg_ff;
   logic [1:0]           k_ff;
   logic [59:0]          prod_ff;
   logic [61:0]          sq_ff, n_ff, r_ff, bit_ff;
   logic [DW-1:0]        rem_ff, dsh_ff;
   logic [QB-1:0]        q_ff;
   logic [4:0]           cnt_ff;
   logic                 done_ff;
   logic [COMP_BITS-1:0] nx_ff, ny_ff, nz_ff;

   logic [MW-1:0]        mag_x, mag_y, mag_z;
   logic                 big, under;
   logic [29:0]          sel;
   logic                 sel_neg;
   logic [61:0]          root_try;
   logic                 ge;
   logic [QB-1:0]        q_in;
   logic [COMP_BITS-1:0] res_in;

   function automatic logic [MW-1:0] mag_of(input logic [ACC_BITS-1:0] s);
      logic signed [40:0] w;
      w = 41'(signed'(s));
      if (w < 0) begin
         w = -w;
      end
      return MW'(w);
   endfunction

   assign mag_x = mag_of(sum_x);
   assign mag_y = mag_of(sum_y);
   assign mag_z = mag_of(sum_z);

   // largest magnitude must end in [2^29, 2^30)
   assign big   = (41'(a_ff) >= 41'h4000_0000) || (41'(b_ff) >= 41'h4000_0000) ||
                  (41'(c_ff) >= 41'h4000_0000);
   assign under = (41'(a_ff) < 41'h2000_0000) && (41'(b_ff) < 41'h2000_0000) &&
                  (41'(c_ff) < 41'h2000_0000);

   always_comb begin
      case (k_ff)
         2'd0: begin
            sel = a_ff[29:0];
            sel_neg = neg_ff[0];
         end
         2'd1: begin
            sel = b_ff[29:0];
            sel_neg = neg_ff[1];
         end
         default: begin
            sel = c_ff[29:0];
            sel_neg = neg_ff[2];
         end
      endcase
   end

   assign root_try = r_ff + bit_ff;
   assign ge       = (rem_ff >= dsh_ff);
   assign q_in     = {q_ff[QB-2:0], ge};
   assign res_in   = sel_neg ? COMP_BITS'(0) - COMP_BITS'(q_in) : COMP_BITS'(q_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == N_IDLE && start && mag_x == '0 && mag_y == '0 &&
                     mag_z == '0) ||
                    (state_ff == N_DIV && cnt_ff == 5'd0 && k_ff == 2'd2);
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  a_ff   <= mag_x;
                  b_ff   <= mag_y;
                  c_ff   <= mag_z;
                  neg_ff <= {sum_z[ACC_BITS-1], sum_y[ACC_BITS-1], sum_x[ACC_BITS-1]};
                  if (mag_x == '0 && mag_y == '0 && mag_z == '0) begin
                     nx_ff   <= '0;
                     ny_ff   <= '0;
                     nz_ff   <= '0;
                  end else begin
                     state_ff <= N_SHIFT;
                  end
               end
            end
            N_SHIFT: begin
               if (big) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
                  c_ff <= c_ff >> 1;
               end else if (under) begin
                  a_ff <= a_ff << 1;
                  b_ff <= b_ff << 1;
                  c_ff <= c_ff << 1;
               end else begin
                  k_ff     <= 2'd0;
                  sq_ff    <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               prod_ff <= 60'(sel) * 60'(sel);
               if (k_ff != 2'd0) begin
                  sq_ff <= sq_ff + 62'(prod_ff);
               end
               if (k_ff == 2'd3) begin
                  n_ff     <= sq_ff + 62'(prod_ff);
                  r_ff     <= '0;
                  bit_ff   <= 62'(1) << 60;
                  k_ff     <= 2'd0;
                  state_ff <= N_SQRT;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            N_SQRT: begin
               if (n_ff >= root_try) begin
                  n_ff <= n_ff - root_try;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 62'd1) begin
                  state_ff <= N_DLD;
               end
            end
            N_DLD: begin
               // (a * 2^(CB-1) + len) / (2 * len), rounding half up
               rem_ff   <= (DW'(sel) << (COMP_BITS - 1)) + DW'(r_ff[30:0]);
               dsh_ff   <= DW'({r_ff[30:0], 1'b0}) << (COMP_BITS - 2);
               q_ff     <= '0;
               cnt_ff   <= 5'(QB - 1);
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               q_ff   <= q_in;
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  case (k_ff)
                     2'd0:    nx_ff <= res_in;
                     2'd1:    ny_ff <= res_in;
                     default: nz_ff <= res_in;
                  endcase
                  if (k_ff == 2'd2) begin
                     state_ff <= N_IDLE;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= N_DLD;
                  end
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != N_IDLE);
   assign stat.done = done_ff;
   assign norm_x    = nx_ff;
   assign norm_y    = ny_ff;
   assign norm_z    = nz_ff;

endmodule

// ===== hdl/tangent_group_average_normalize.sv =====
// Accumulate beats add a tangent into its vertex's sum. Drain beats scan the 32-index
// presence rows from the cursor, normalise the first set entry (shift, square, root and
// divide steps), then check the rows above the hit for last.
// One beat is worked at a time; the result register lets the next beat enter while
// a result waits. After reset a clearing pass over the ceil(MAX_VERTS/32) presence rows (128 by
// default) wipes the presence memory; no beat is accepted until it ends.
`timescale 1ns / 1ps

module tangent_group_average_normalize #(
   parameter int MAX_VERTS = 4096,
   parameter int ACC_BITS  = 24,
   parameter int COMP_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [tgan_pkg::IDX_BITS-1:0] req_vertex_index,
   input  logic [COMP_BITS-1:0]          req_tan_x,
   input  logic [COMP_BITS-1:0]          req_tan_y,
   input  logic [COMP_BITS-1:0]          req_tan_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tgan_pkg::IDX_BITS-1:0] rsp_out_index,
   output logic [COMP_BITS-1:0]          rsp_norm_x,
   output logic [COMP_BITS-1:0]          rsp_norm_y,
   output logic [COMP_BITS-1:0]          rsp_norm_z,
   output logic                          rsp_found,
   output logic                          rsp_last
);

   localparam int PW   = tgan_pkg::PRES_W;
   localparam int PB   = tgan_pkg::PB;
   localparam int ROWS = (MAX_VERTS + PW - 1) / PW;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int HW   = RW + PB;
   localparam int IW   = $clog2(MAX_VERTS);
   localparam int SW   = 3 * ACC_BITS;
   localparam int XW   = 42;
   localparam logic signed [XW-1:0] ACC_MAX = (XW'(1) << (ACC_BITS - 1)) - XW'(1);
   localparam logic signed [XW-1:0] ACC_MIN = -ACC_MAX - XW'(1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_ACC      = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CHK = 4'd4;
   localparam logic [3:0] S_SUM      = 4'd5;
   localparam logic [3:0] S_WAIT     = 4'd6;
   localparam logic [3:0] S_POST     = 4'd7;
   localparam logic [3:0] S_ANY_RD   = 4'd8;
   localparam logic [3:0] S_ANY_CHK  = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   logic [SW-1:0] sum_mem [MAX_VERTS];
   logic [PW-1:0] pres_mem [ROWS];

   logic [3:0]           state_ff;
   logic [RW-1:0]        clr_ff;
   logic [RW-1:0]        row_ff;
   logic                 first_ff;
   logic [HW-1:0]        cursor_ff;
   logic [HW-1:0]        hit_ff;
   logic                 found_ff;
   logic                 any_ff;
   logic [SW-1:0]        sum_q_ff;
   logic [PW-1:0]        pres_q_ff;
   logic [IW-1:0]        aaddr_ff;
   logic [PB-1:0]        apos_ff;
   logic                 oor_ff;
   logic [COMP_BITS-1:0] tx_ff, ty_ff, tz_ff;

   logic                    rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [tgan_pkg::IDX_BITS-1:0] rsp_index_ff;
   logic [COMP_BITS-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic          req_acc;
   logic          pres_we;
   logic [RW-1:0] pres_wa, pres_ra;
   logic [PW-1:0] pres_wd;
   logic          sum_we;
   logic [IW-1:0] sum_ra;
   logic [SW-1:0] sum_wd;
   logic [PW-1:0] keep, avail, lowbit;
   logic [PB-1:0] pos_c;
   logic [HW-1:0] hit_c;
   logic          old_here;
   logic [ACC_BITS-1:0] old_x, old_y, old_z;
   logic          norm_go;
   logic          out_free;
   tgan_pkg::norm_stat_type norm_stat;
   logic [COMP_BITS-1:0] nx, ny, nz;

   function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] acc,
                                                   input logic [COMP_BITS-1:0] t);
      logic signed [XW-1:0] s;
      s = XW'(signed'(acc)) + XW'(signed'(t));
      if (s > ACC_MAX) begin
         s = ACC_MAX;
      end else if (s < ACC_MIN) begin
         s = ACC_MIN;
      end
      return ACC_BITS'(s);
   endfunction

   function automatic logic [PB-1:0] low_pos(input logic [PW-1:0] v);
      logic [PB-1:0] p;
      p = '0;
      for (int i = PW - 1; i >= 0; i--) begin
         if (v[i]) begin
            p = PB'(i);
         end
      end
      return p;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // scan window: the first row starts at the cursor's bit
   assign keep   = first_ff ? ~((PW'(1) << cursor_ff[PB-1:0]) - PW'(1)) : '1;
   assign avail  = pres_q_ff & keep;
   assign lowbit = avail & (~avail + PW'(1));
   assign pos_c  = low_pos(avail);
   assign hit_c  = {row_ff, pos_c};

   assign pres_ra = (state_ff == S_IDLE) ? RW'(req_vertex_index >> PB) : row_ff;
   assign sum_ra  = (state_ff == S_SCAN_CHK) ? IW'(hit_c) : IW'(req_vertex_index);

   // a sum whose flag is clear counts as zero, so the sum memory needs no clearing
   assign old_here = pres_q_ff[apos_ff];
   assign old_x = old_here ? sum_q_ff[SW-1 -: ACC_BITS] : '0;
   assign old_y = old_here ? sum_q_ff[2*ACC_BITS-1 -: ACC_BITS] : '0;
   assign old_z = old_here ? sum_q_ff[ACC_BITS-1:0] : '0;
   assign sum_wd = {sat_add(old_x, tx_ff), sat_add(old_y, ty_ff), sat_add(old_z, tz_ff)};
   assign sum_we = (state_ff == S_ACC) && !oor_ff;

   always_comb begin
      pres_we = 1'b0;
      pres_wa = row_ff;
      pres_wd = '0;
      case (state_ff)
         S_CLEAR: begin
            pres_we = 1'b1;
            pres_wa = clr_ff;
         end
         S_ACC: begin
            pres_we = !oor_ff;
            pres_wa = RW'(aaddr_ff >> PB);
            pres_wd = pres_q_ff | (PW'(1) << apos_ff);
         end
         S_SCAN_CHK: begin
            pres_we = (avail != '0);
            pres_wd = pres_q_ff & ~lowbit;
         end
         default: begin
            pres_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_wa] <= pres_wd;
      end
      pres_q_ff <= pres_mem[pres_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[aaddr_ff] <= sum_wd;
      end
      sum_q_ff <= sum_mem[sum_ra];
   end

   assign norm_go = (state_ff == S_SUM);

   tgan_norm #(
      .ACC_BITS  (ACC_BITS),
      .COMP_BITS (COMP_BITS)
   ) u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_go),
      .sum_x  (sum_q_ff[SW-1 -: ACC_BITS]),
      .sum_y  (sum_q_ff[2*ACC_BITS-1 -: ACC_BITS]),
      .sum_z  (sum_q_ff[ACC_BITS-1:0]),
      .stat   (norm_stat),
      .norm_x (nx),
      .norm_y (ny),
      .norm_z (nz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output state reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + RW'(1);
               if (clr_ff == RW'(ROWS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  if (req_type) begin
                     row_ff   <= cursor_ff[HW-1:PB];
                     first_ff <= 1'b1;
                     state_ff <= S_SCAN_RD;
                  end else begin
                     aaddr_ff <= IW'(req_vertex_index);
                     apos_ff  <= req_vertex_index[PB-1:0];
                     oor_ff   <= (32'(req_vertex_index) >= 32'(MAX_VERTS));
                     tx_ff    <= req_tan_x;
                     ty_ff    <= req_tan_y;
                     tz_ff    <= req_tan_z;
                     state_ff <= S_ACC;
                  end
               end
            end
            S_ACC: begin
               state_ff <= S_IDLE;
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               first_ff <= 1'b0;
               if (avail != '0) begin
                  hit_ff   <= hit_c;
                  found_ff <= 1'b1;
                  any_ff   <= ((avail & ~lowbit) != '0);
                  state_ff <= S_SUM;
               end else if (row_ff == RW'(ROWS - 1)) begin
                  found_ff <= 1'b0;
                  any_ff   <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + RW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SUM: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (norm_stat.done) begin
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               if (any_ff || row_ff == RW'(ROWS - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + RW'(1);
                  state_ff <= S_ANY_RD;
               end
            end
            S_ANY_RD: begin
               state_ff <= S_ANY_CHK;
            end
            S_ANY_CHK: begin
               if (pres_q_ff != '0) begin
                  any_ff   <= 1'b1;
                  state_ff <= S_OUT;
               end else if (row_ff == RW'(ROWS - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + RW'(1);
                  state_ff <= S_ANY_RD;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_last_ff  <= !any_ff;
                  rsp_index_ff <= found_ff ? tgan_pkg::IDX_BITS'(hit_ff) : '0;
                  rsp_x_ff     <= found_ff ? nx : '0;
                  rsp_y_ff     <= found_ff ? ny : '0;
                  rsp_z_ff     <= found_ff ? nz : '0;
                  if (found_ff && (32'(hit_ff) + 32'd1 < 32'(MAX_VERTS))) begin
                     cursor_ff <= hit_ff + HW'(1);
                  end else begin
                     cursor_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_norm_x    = rsp_x_ff;
   assign rsp_norm_y    = rsp_y_ff;
   assign rsp_norm_z    = rsp_z_ff;

`ifndef ASSERT_OFF
   a_norm_done_waits: assert property (@(posedge clock) disable iff (reset)
      norm_stat.done |-> state_ff == S_WAIT)
      else $error("normaliser finished outside the wait state");

   a_norm_idle_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !norm_stat.busy)
      else $error("normaliser busy while block idle");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < 32'(MAX_VERTS))
      else $error("drain cursor out of range");

   a_miss_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_last_ff && rsp_x_ff == '0 &&
         rsp_y_ff == '0 && rsp_z_ff == '0 && rsp_index_ff == '0))
      else $error("not-found result carries data");
`endif

endmodule
